FILE: rtl/fluid_cell_velocity_update_top_defines.svh
// assertion macros shared by the fluid cell velocity update rtl
`ifndef FLUID_CELL_VELOCITY_UPDATE_TOP_DEFINES_SVH
`define FLUID_CELL_VELOCITY_UPDATE_TOP_DEFINES_SVH

// consequent holds in the same cycle
`define FCVU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define FCVU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fcvu_pkg.sv
// types, constants and arithmetic helpers of the fluid cell velocity update
`default_nettype none
package fcvu_pkg;

    localparam int DEPTH = 37;
    localparam logic [5:0] SLOT_RHO = 6'd6;
    localparam logic [5:0] SLOT_VEL = 6'd7;
    localparam logic [5:0] SLOT_COEF = 6'd10;
    localparam logic [5:0] COEF_STRIDE_A = 6'd9;
    localparam logic [5:0] COEF_STRIDE_B = 6'd3;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_DT = 3'd1;
    localparam logic [2:0] REG_INV_X = 3'd2;
    localparam logic [2:0] REG_INV_Y = 3'd3;
    localparam logic [2:0] REG_INV_Z = 3'd4;
    localparam logic [2:0] REG_VTH = 3'd5;

    localparam logic signed [64:0] WMAX_W = 65'sd2147483647;
    localparam logic signed [64:0] WMIN_W = -65'sd2147483648;

    typedef logic signed [31:0] word_t;

    typedef enum logic [1:0] {
        RES_UPDATED = 2'd0,
        RES_VACUUM = 2'd1,
        RES_ZERO = 2'd2,
        RES_SATURATED = 2'd3
    } res_status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_TAKE_RHO,
        OP_TAKE_V,
        OP_TAKE_PP,
        OP_DIFF_MUL,
        OP_GRAD,
        OP_DIV_GO,
        OP_Q,
        OP_QDT_MUL,
        OP_NV0,
        OP_DOT_MUL,
        OP_ACC,
        OP_RHO_MUL,
        OP_NRHO,
        OP_VV_MUL,
        OP_VV,
        OP_G_MUL,
        OP_CONN_MUL,
        OP_NV1,
        OP_PUSH
    } dp_op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_F_RHO,
        ST_T_RHO,
        ST_F_V,
        ST_T_V,
        ST_CHECK,
        ST_F_PP,
        ST_T_PP,
        ST_F_PM,
        ST_T_PM,
        ST_GW,
        ST_GRAD,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_Q,
        ST_QDT,
        ST_QDW,
        ST_NV0,
        ST_DOT,
        ST_DOTW,
        ST_DOTACC,
        ST_RHOM,
        ST_RHOW,
        ST_NRHO,
        ST_VV,
        ST_VVW,
        ST_VVU,
        ST_GM,
        ST_GMW,
        ST_GACC,
        ST_CONN,
        ST_CONNW,
        ST_NV1,
        ST_PUSH
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic rd_en;
        logic [5:0] rd_addr;
        logic [1:0] ax;
        logic [1:0] bx;
        logic [1:0] cx;
        res_status_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic vacuum;
        logic zero_rho;
        logic mode;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic ovf;
        word_t val;
    } satw_t;

    function automatic satw_t sat_w(input logic signed [64:0] x);
        satw_t r;
        if (x > WMAX_W) begin
            r.ovf = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end else if (x < WMIN_W) begin
            r.ovf = 1'b1;
            r.val = 32'sh80000000;
        end else begin
            r.ovf = 1'b0;
            r.val = x[31:0];
        end
        return r;
    endfunction

    // round to nearest, ties up, of a q32.32 product, then saturate
    function automatic satw_t rnd_w(input logic signed [63:0] p);
        logic signed [64:0] y;
        y = (65'(p) + 65'sd32768) >>> 16;
        return sat_w(y);
    endfunction

    function automatic word_t pick3(input word_t w0, input word_t w1, input word_t w2,
                                    input logic [1:0] sel);
        word_t r;
        unique case (sel)
            2'd1: r = w1;
            2'd2: r = w2;
            default: r = w0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fcvu_div.sv
// bit-serial signed divider for the q16.16 quotient, one bit a cycle
`default_nettype none
module fcvu_div (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire fcvu_pkg::word_t num,
    input  wire fcvu_pkg::word_t den,
    output logic busy,
    output fcvu_pkg::word_t quot,
    output logic ovf
);

    logic busy_reg, busy_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [47:0] sh_reg, sh_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic neg_reg, neg_next;
    logic [32:0] rem_sh;
    logic [31:0] num_mag;
    logic [31:0] den_mag;

    always_comb
    begin
        num_mag = num[31] ? 32'(~num + 32'sd1) : 32'(num);
        den_mag = den[31] ? 32'(~den + 32'sd1) : 32'(den);
        rem_sh = {rem_reg, sh_reg[47]};
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        sh_next = sh_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = 6'd48;
            sh_next = {num_mag, 16'd0};
            rem_next = 32'd0;
            den_next = den_mag;
            neg_next = num[31] ^ den[31];
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next = 32'(rem_sh - {1'b0, den_reg});
                sh_next = {sh_reg[46:0], 1'b1};
            end else begin
                rem_next = rem_sh[31:0];
                sh_next = {sh_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        busy = busy_reg;
        if (neg_reg) begin
            if (sh_reg > 48'h80000000) begin
                ovf = 1'b1;
                quot = 32'sh80000000;
            end else begin
                ovf = 1'b0;
                quot = 32'(~sh_reg[31:0] + 32'd1);
            end
        end else begin
            if (sh_reg > 48'h7FFFFFFF) begin
                ovf = 1'b1;
                quot = 32'sh7FFFFFFF;
            end else begin
                ovf = 1'b0;
                quot = sh_reg[31:0];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fcvu_datapath.sv
// operand store, registers, shared multiplier and result register
`default_nettype none
module fcvu_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_accept,
    input  wire logic [5:0] in_slot,
    input  wire fcvu_pkg::word_t in_value,
    input  wire fcvu_pkg::dp_cmd_t cmd,
    output fcvu_pkg::dp_stat_t stat,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [4:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    input  wire logic out_ready,
    output logic out_valid,
    output fcvu_pkg::word_t out_vx,
    output fcvu_pkg::word_t out_vy,
    output fcvu_pkg::word_t out_vz,
    output fcvu_pkg::word_t out_rho,
    output logic [1:0] out_status
);

    fcvu_pkg::word_t mem [fcvu_pkg::DEPTH];
    fcvu_pkg::word_t rd_data_reg;

    logic mode_reg;
    logic [30:0] dt_reg;
    logic [30:0] inv_reg [3];
    logic [30:0] vth_reg;

    fcvu_pkg::word_t rho_reg, nrho_reg, pp_reg, vv_reg;
    fcvu_pkg::word_t v_reg [3];
    fcvu_pkg::word_t nv_reg [3];
    fcvu_pkg::word_t grad_reg [3];
    fcvu_pkg::word_t q_reg [3];
    fcvu_pkg::word_t mul_a_reg, mul_b_reg;
    logic signed [63:0] prod_reg;
    logic signed [36:0] acc_reg;
    logic sat_reg;

    logic out_valid_reg;
    fcvu_pkg::word_t out_vx_reg, out_vy_reg, out_vz_reg, out_rho_reg;
    logic [1:0] out_status_reg;

    fcvu_pkg::word_t v_a, v_b, v_c, nv_a, grad_a, q_a, inv_a, dt_w;
    fcvu_pkg::satw_t rnd_p, diff, acc_sat, nv_new, qc, nrho_new;
    logic div_start, div_busy, div_ovf;
    fcvu_pkg::word_t div_q;
    logic out_free;

    fcvu_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(grad_a),
        .den(rho_reg),
        .busy(div_busy),
        .quot(div_q),
        .ovf(div_ovf)
    );

    always_ff @(posedge clk)
    begin
        if (in_accept && (in_slot < 6'(fcvu_pkg::DEPTH)))
            mem[in_slot] <= in_value;
        if (cmd.rd_en)
            rd_data_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= 1'b1;
            dt_reg <= 31'd655;
            inv_reg[0] <= 31'd65536;
            inv_reg[1] <= 31'd65536;
            inv_reg[2] <= 31'd65536;
            vth_reg <= 31'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                fcvu_pkg::REG_MODE: mode_reg <= pwdata[0];
                fcvu_pkg::REG_DT: dt_reg <= pwdata[30:0];
                fcvu_pkg::REG_INV_X: inv_reg[0] <= pwdata[30:0];
                fcvu_pkg::REG_INV_Y: inv_reg[1] <= pwdata[30:0];
                fcvu_pkg::REG_INV_Z: inv_reg[2] <= pwdata[30:0];
                fcvu_pkg::REG_VTH: vth_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            fcvu_pkg::REG_MODE: prdata = {31'd0, mode_reg};
            fcvu_pkg::REG_DT: prdata = {1'b0, dt_reg};
            fcvu_pkg::REG_INV_X: prdata = {1'b0, inv_reg[0]};
            fcvu_pkg::REG_INV_Y: prdata = {1'b0, inv_reg[1]};
            fcvu_pkg::REG_INV_Z: prdata = {1'b0, inv_reg[2]};
            fcvu_pkg::REG_VTH: prdata = {1'b0, vth_reg};
            default: prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        v_a = fcvu_pkg::pick3(v_reg[0], v_reg[1], v_reg[2], cmd.ax);
        v_b = fcvu_pkg::pick3(v_reg[0], v_reg[1], v_reg[2], cmd.bx);
        v_c = fcvu_pkg::pick3(v_reg[0], v_reg[1], v_reg[2], cmd.cx);
        nv_a = fcvu_pkg::pick3(nv_reg[0], nv_reg[1], nv_reg[2], cmd.ax);
        grad_a = fcvu_pkg::pick3(grad_reg[0], grad_reg[1], grad_reg[2], cmd.ax);
        q_a = fcvu_pkg::pick3(q_reg[0], q_reg[1], q_reg[2], cmd.ax);
        inv_a = fcvu_pkg::pick3({1'b0, inv_reg[0]}, {1'b0, inv_reg[1]}, {1'b0, inv_reg[2]},
                                cmd.ax);
        dt_w = {1'b0, dt_reg};
        rnd_p = fcvu_pkg::rnd_w(prod_reg);
        diff = fcvu_pkg::sat_w(65'(pp_reg) - 65'(rd_data_reg));
        acc_sat = fcvu_pkg::sat_w(65'(acc_reg));
        nv_new = fcvu_pkg::sat_w(65'(v_a) - 65'(rnd_p.val));
        qc = fcvu_pkg::sat_w(65'(q_a) + 65'(acc_sat.val));
        nrho_new = fcvu_pkg::sat_w(65'(rho_reg) - 65'(rnd_p.val));
        div_start = (cmd.op == fcvu_pkg::OP_DIV_GO);
        out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a_reg * mul_b_reg;
        unique case (cmd.op)
            fcvu_pkg::OP_START: acc_reg <= 37'sd0;
            fcvu_pkg::OP_TAKE_RHO:
            begin
                rho_reg <= rd_data_reg;
                nrho_reg <= rd_data_reg;
            end
            fcvu_pkg::OP_TAKE_V:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.ax == 2'(i)) begin
                        v_reg[i] <= rd_data_reg;
                        nv_reg[i] <= rd_data_reg;
                    end
                end
            end
            fcvu_pkg::OP_TAKE_PP: pp_reg <= rd_data_reg;
            fcvu_pkg::OP_DIFF_MUL:
            begin
                mul_a_reg <= diff.val;
                mul_b_reg <= inv_a;
            end
            fcvu_pkg::OP_GRAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.ax == 2'(i))
                        grad_reg[i] <= rnd_p.val;
                end
            end
            fcvu_pkg::OP_Q:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.ax == 2'(i))
                        q_reg[i] <= div_q;
                end
            end
            fcvu_pkg::OP_QDT_MUL:
            begin
                mul_a_reg <= q_a;
                mul_b_reg <= dt_w;
            end
            fcvu_pkg::OP_NV0, fcvu_pkg::OP_NV1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.ax == 2'(i))
                        nv_reg[i] <= nv_new.val;
                end
                if (cmd.op == fcvu_pkg::OP_NV1)
                    acc_reg <= 37'sd0;
            end
            fcvu_pkg::OP_DOT_MUL:
            begin
                mul_a_reg <= nv_a;
                mul_b_reg <= grad_a;
            end
            fcvu_pkg::OP_ACC: acc_reg <= acc_reg + 37'(rnd_p.val);
            fcvu_pkg::OP_RHO_MUL:
            begin
                mul_a_reg <= acc_sat.val;
                mul_b_reg <= dt_w;
            end
            fcvu_pkg::OP_NRHO: nrho_reg <= nrho_new.val;
            fcvu_pkg::OP_VV_MUL:
            begin
                mul_a_reg <= v_b;
                mul_b_reg <= v_c;
            end
            fcvu_pkg::OP_VV: vv_reg <= rnd_p.val;
            fcvu_pkg::OP_G_MUL:
            begin
                mul_a_reg <= rd_data_reg;
                mul_b_reg <= vv_reg;
            end
            fcvu_pkg::OP_CONN_MUL:
            begin
                mul_a_reg <= qc.val;
                mul_b_reg <= dt_w;
            end
            fcvu_pkg::OP_PUSH:
            begin
                out_vx_reg <= nv_reg[0];
                out_vy_reg <= nv_reg[1];
                out_vz_reg <= nv_reg[2];
                out_rho_reg <= nrho_reg;
                if (cmd.kind == fcvu_pkg::RES_UPDATED && sat_reg)
                    out_status_reg <= fcvu_pkg::RES_SATURATED;
                else
                    out_status_reg <= cmd.kind;
            end
            default: ;
        endcase
    end

    // saturation seen anywhere during the update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sat_reg <= 1'b0;
        end else begin
            unique case (cmd.op)
                fcvu_pkg::OP_START: sat_reg <= 1'b0;
                fcvu_pkg::OP_DIFF_MUL: sat_reg <= sat_reg | diff.ovf;
                fcvu_pkg::OP_GRAD, fcvu_pkg::OP_ACC, fcvu_pkg::OP_VV:
                    sat_reg <= sat_reg | rnd_p.ovf;
                fcvu_pkg::OP_Q: sat_reg <= sat_reg | div_ovf;
                fcvu_pkg::OP_NV0, fcvu_pkg::OP_NV1:
                    sat_reg <= sat_reg | rnd_p.ovf | nv_new.ovf;
                fcvu_pkg::OP_RHO_MUL: sat_reg <= sat_reg | acc_sat.ovf;
                fcvu_pkg::OP_NRHO: sat_reg <= sat_reg | rnd_p.ovf | nrho_new.ovf;
                fcvu_pkg::OP_CONN_MUL: sat_reg <= sat_reg | acc_sat.ovf | qc.ovf;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == fcvu_pkg::OP_PUSH)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        stat.vacuum = mode_reg && (rho_reg < $signed({1'b0, vth_reg}));
        stat.zero_rho = (rho_reg == 32'sd0);
        stat.mode = mode_reg;
        stat.div_busy = div_busy;
        stat.out_free = out_free;
        out_valid = out_valid_reg;
        out_vx = out_vx_reg;
        out_vy = out_vy_reg;
        out_vz = out_vz_reg;
        out_rho = out_rho_reg;
        out_status = out_status_reg;
    end

endmodule
`default_nettype wire

FILE: rtl/fcvu_ctrl.sv
// sequencer that steps the datapath through one cell update
`default_nettype none
`include "fluid_cell_velocity_update_top_defines.svh"
module fcvu_ctrl #(
    parameter int DIMS = 3
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_accept,
    input  wire logic in_last,
    output logic in_ready,
    input  wire fcvu_pkg::dp_stat_t stat,
    output fcvu_pkg::dp_cmd_t cmd
);

    localparam logic [1:0] LAST_AX = 2'(DIMS - 1);

    fcvu_pkg::ctl_state_t state_reg, state_next;
    logic [1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    fcvu_pkg::res_status_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= fcvu_pkg::ST_IDLE;
            a_reg <= 2'd0;
            b_reg <= 2'd0;
            c_reg <= 2'd0;
            kind_reg <= fcvu_pkg::RES_UPDATED;
        end else begin
            state_reg <= state_next;
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            kind_reg <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        kind_next = kind_reg;
        unique case (state_reg)
            fcvu_pkg::ST_IDLE:
                if (in_accept && in_last) state_next = fcvu_pkg::ST_F_RHO;
            fcvu_pkg::ST_F_RHO: state_next = fcvu_pkg::ST_T_RHO;
            fcvu_pkg::ST_T_RHO:
            begin
                a_next = 2'd0;
                state_next = fcvu_pkg::ST_F_V;
            end
            fcvu_pkg::ST_F_V: state_next = fcvu_pkg::ST_T_V;
            fcvu_pkg::ST_T_V:
            begin
                if (a_reg == 2'd2) begin
                    a_next = 2'd0;
                    state_next = fcvu_pkg::ST_CHECK;
                end else begin
                    a_next = a_reg + 2'd1;
                    state_next = fcvu_pkg::ST_F_V;
                end
            end
            fcvu_pkg::ST_CHECK:
            begin
                if (stat.vacuum) begin
                    kind_next = fcvu_pkg::RES_VACUUM;
                    state_next = fcvu_pkg::ST_PUSH;
                end else if (stat.zero_rho) begin
                    kind_next = fcvu_pkg::RES_ZERO;
                    state_next = fcvu_pkg::ST_PUSH;
                end else begin
                    kind_next = fcvu_pkg::RES_UPDATED;
                    state_next = fcvu_pkg::ST_F_PP;
                end
            end
            fcvu_pkg::ST_F_PP: state_next = fcvu_pkg::ST_T_PP;
            fcvu_pkg::ST_T_PP: state_next = fcvu_pkg::ST_F_PM;
            fcvu_pkg::ST_F_PM: state_next = fcvu_pkg::ST_T_PM;
            fcvu_pkg::ST_T_PM: state_next = fcvu_pkg::ST_GW;
            fcvu_pkg::ST_GW: state_next = fcvu_pkg::ST_GRAD;
            fcvu_pkg::ST_GRAD: state_next = fcvu_pkg::ST_DIV_GO;
            fcvu_pkg::ST_DIV_GO: state_next = fcvu_pkg::ST_DIV_RUN;
            fcvu_pkg::ST_DIV_RUN:
                if (!stat.div_busy) state_next = fcvu_pkg::ST_Q;
            fcvu_pkg::ST_Q:
            begin
                if (a_reg == LAST_AX) begin
                    a_next = 2'd0;
                    b_next = 2'd0;
                    c_next = 2'd0;
                    state_next = stat.mode ? fcvu_pkg::ST_VV : fcvu_pkg::ST_QDT;
                end else begin
                    a_next = a_reg + 2'd1;
                    state_next = fcvu_pkg::ST_F_PP;
                end
            end
            fcvu_pkg::ST_QDT: state_next = fcvu_pkg::ST_QDW;
            fcvu_pkg::ST_QDW: state_next = fcvu_pkg::ST_NV0;
            fcvu_pkg::ST_NV0:
            begin
                if (a_reg == LAST_AX) begin
                    a_next = 2'd0;
                    state_next = fcvu_pkg::ST_DOT;
                end else begin
                    a_next = a_reg + 2'd1;
                    state_next = fcvu_pkg::ST_QDT;
                end
            end
            fcvu_pkg::ST_DOT: state_next = fcvu_pkg::ST_DOTW;
            fcvu_pkg::ST_DOTW: state_next = fcvu_pkg::ST_DOTACC;
            fcvu_pkg::ST_DOTACC:
            begin
                if (a_reg == LAST_AX) begin
                    a_next = 2'd0;
                    state_next = fcvu_pkg::ST_RHOM;
                end else begin
                    a_next = a_reg + 2'd1;
                    state_next = fcvu_pkg::ST_DOT;
                end
            end
            fcvu_pkg::ST_RHOM: state_next = fcvu_pkg::ST_RHOW;
            fcvu_pkg::ST_RHOW: state_next = fcvu_pkg::ST_NRHO;
            fcvu_pkg::ST_NRHO: state_next = fcvu_pkg::ST_PUSH;
            fcvu_pkg::ST_VV: state_next = fcvu_pkg::ST_VVW;
            fcvu_pkg::ST_VVW: state_next = fcvu_pkg::ST_VVU;
            fcvu_pkg::ST_VVU: state_next = fcvu_pkg::ST_GM;
            fcvu_pkg::ST_GM: state_next = fcvu_pkg::ST_GMW;
            fcvu_pkg::ST_GMW: state_next = fcvu_pkg::ST_GACC;
            fcvu_pkg::ST_GACC:
            begin
                if (c_reg != LAST_AX) begin
                    c_next = c_reg + 2'd1;
                    state_next = fcvu_pkg::ST_VV;
                end else if (b_reg != LAST_AX) begin
                    b_next = b_reg + 2'd1;
                    c_next = 2'd0;
                    state_next = fcvu_pkg::ST_VV;
                end else begin
                    b_next = 2'd0;
                    c_next = 2'd0;
                    state_next = fcvu_pkg::ST_CONN;
                end
            end
            fcvu_pkg::ST_CONN: state_next = fcvu_pkg::ST_CONNW;
            fcvu_pkg::ST_CONNW: state_next = fcvu_pkg::ST_NV1;
            fcvu_pkg::ST_NV1:
            begin
                if (a_reg == LAST_AX) begin
                    a_next = 2'd0;
                    state_next = fcvu_pkg::ST_PUSH;
                end else begin
                    a_next = a_reg + 2'd1;
                    state_next = fcvu_pkg::ST_VV;
                end
            end
            fcvu_pkg::ST_PUSH:
                if (stat.out_free) state_next = fcvu_pkg::ST_IDLE;
            default: state_next = fcvu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == fcvu_pkg::ST_IDLE);
        cmd.op = fcvu_pkg::OP_NONE;
        cmd.rd_en = 1'b0;
        cmd.rd_addr = 6'd0;
        cmd.ax = a_reg;
        cmd.bx = b_reg;
        cmd.cx = c_reg;
        cmd.kind = kind_reg;
        unique case (state_reg)
            fcvu_pkg::ST_IDLE:
                if (in_accept && in_last) cmd.op = fcvu_pkg::OP_START;
            fcvu_pkg::ST_F_RHO:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_addr = fcvu_pkg::SLOT_RHO;
            end
            fcvu_pkg::ST_T_RHO: cmd.op = fcvu_pkg::OP_TAKE_RHO;
            fcvu_pkg::ST_F_V:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_addr = fcvu_pkg::SLOT_VEL + {4'd0, a_reg};
            end
            fcvu_pkg::ST_T_V: cmd.op = fcvu_pkg::OP_TAKE_V;
            fcvu_pkg::ST_F_PP:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_addr = {3'd0, a_reg, 1'b0};
            end
            fcvu_pkg::ST_T_PP: cmd.op = fcvu_pkg::OP_TAKE_PP;
            fcvu_pkg::ST_F_PM:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_addr = {3'd0, a_reg, 1'b1};
            end
            fcvu_pkg::ST_T_PM: cmd.op = fcvu_pkg::OP_DIFF_MUL;
            fcvu_pkg::ST_GRAD: cmd.op = fcvu_pkg::OP_GRAD;
            fcvu_pkg::ST_DIV_GO: cmd.op = fcvu_pkg::OP_DIV_GO;
            fcvu_pkg::ST_Q: cmd.op = fcvu_pkg::OP_Q;
            fcvu_pkg::ST_QDT: cmd.op = fcvu_pkg::OP_QDT_MUL;
            fcvu_pkg::ST_NV0: cmd.op = fcvu_pkg::OP_NV0;
            fcvu_pkg::ST_DOT: cmd.op = fcvu_pkg::OP_DOT_MUL;
            fcvu_pkg::ST_DOTACC, fcvu_pkg::ST_GACC: cmd.op = fcvu_pkg::OP_ACC;
            fcvu_pkg::ST_RHOM: cmd.op = fcvu_pkg::OP_RHO_MUL;
            fcvu_pkg::ST_NRHO: cmd.op = fcvu_pkg::OP_NRHO;
            fcvu_pkg::ST_VV:
            begin
                cmd.op = fcvu_pkg::OP_VV_MUL;
                cmd.rd_en = 1'b1;
                cmd.rd_addr = fcvu_pkg::SLOT_COEF
                              + 6'({4'd0, a_reg} * fcvu_pkg::COEF_STRIDE_A)
                              + 6'({4'd0, b_reg} * fcvu_pkg::COEF_STRIDE_B)
                              + {4'd0, c_reg};
            end
            fcvu_pkg::ST_VVU: cmd.op = fcvu_pkg::OP_VV;
            fcvu_pkg::ST_GM: cmd.op = fcvu_pkg::OP_G_MUL;
            fcvu_pkg::ST_CONN: cmd.op = fcvu_pkg::OP_CONN_MUL;
            fcvu_pkg::ST_NV1: cmd.op = fcvu_pkg::OP_NV1;
            fcvu_pkg::ST_PUSH:
                if (stat.out_free) cmd.op = fcvu_pkg::OP_PUSH;
            default: ;
        endcase
    end

    `FCVU_ASSERT_NOW(a_div_start_idle, state_reg == fcvu_pkg::ST_DIV_GO, !stat.div_busy, "divider started while busy")
    `FCVU_ASSERT_NEXT(a_div_done_take, (state_reg == fcvu_pkg::ST_DIV_RUN) && !stat.div_busy, state_reg == fcvu_pkg::ST_Q, "quotient not taken after divide")
    `FCVU_ASSERT_NEXT(a_push_hold, (state_reg == fcvu_pkg::ST_PUSH) && !stat.out_free, state_reg == fcvu_pkg::ST_PUSH, "result dropped while output busy")

endmodule
`default_nettype wire

FILE: rtl/fluid_cell_velocity_update_top.sv
// top level of the fluid cell velocity update block
`default_nettype none
// Each input item loads one Q16.16 word into the 37-entry operand store. The
// item marked last starts the cell update, during which no item is taken:
// words are read from the store one at a time, a single 32x32 multiplier is
// shared by every product, and each axis quotient comes from a bit-serial
// divider. With three axes, mode 1 also works through 27 connection terms;
// a cell with vacuum or zero density skips the arithmetic. The result waits
// in an output register, and loads for the next cell are taken while it
// waits.
module fluid_cell_velocity_update_top #(
    parameter int DIMS = 3
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // slot[5:0], value[37:6], zero pad
    input  wire logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  wire logic m_axis_tready,
    output logic [135:0] m_axis_tdata,      // new_vx, new_vy, new_vz, new_density, status, pad
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [4:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);

    fcvu_pkg::dp_cmd_t cmd;
    fcvu_pkg::dp_stat_t stat;
    logic in_accept;
    fcvu_pkg::word_t out_vx, out_vy, out_vz, out_rho;
    logic [1:0] out_status;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign pready = 1'b1;
    assign m_axis_tdata = {6'd0, out_status, out_rho, out_vz, out_vy, out_vx};

    fcvu_ctrl #(
        .DIMS(DIMS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_accept(in_accept),
        .in_last(s_axis_tlast),
        .in_ready(s_axis_tready),
        .stat(stat),
        .cmd(cmd)
    );

    fcvu_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .in_accept(in_accept),
        .in_slot(s_axis_tdata[5:0]),
        .in_value(s_axis_tdata[37:6]),
        .cmd(cmd),
        .stat(stat),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .out_ready(m_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_vx(out_vx),
        .out_vy(out_vy),
        .out_vz(out_vz),
        .out_rho(out_rho),
        .out_status(out_status)
    );

endmodule
`default_nettype wire

FILE: tb/fluid_cell_velocity_update_top_test.sv
// testbench for the fluid cell velocity update block with a self-checking predictor
`timescale 1ns / 100ps
`default_nettype none
module fluid_cell_velocity_update_top_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 500;

    typedef struct packed {
        logic [5:0] slot;
        logic signed [31:0] value;
        logic last;
    } load_item_t;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] rho;
        fcvu_pkg::res_status_t status;
    } cell_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [39:0] s_axis_tdata;  // slot, value, pad
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [135:0] m_axis_tdata;  // new_vx, new_vy, new_vz, new_density, status, pad
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    fluid_cell_velocity_update_top DUT (.*);

    load_item_t pending_loads[$];
    cell_result_t expected_cells[$];
    longint cell_store[37];
    logic cfg_mode;
    longint cfg_dt;
    longint cfg_inv[3];
    longint cfg_vth;
    bit clamp_seen;
    int error_count;
    int idle_cycles;
    int send_wait;
    int recv_wait;
    bit in_taken;
    bit out_taken;
    bit [36:0] written;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic longint clamp_word(input longint x);
        if (x > 64'sd2147483647)
        begin
            clamp_seen = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            clamp_seen = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        longint y;
        y = a * b + 32768;
        return clamp_word(y >>> 16);
    endfunction

    function automatic cell_result_t update_cell();
        cell_result_t r;
        longint rho, nrho, grad[3], v[3], nv[3], q[3], dot, conn, diff;
        clamp_seen = 1'b0;
        rho = cell_store[fcvu_pkg::SLOT_RHO];
        nrho = rho;
        for (int a = 0; a < 3; a++)
        begin
            v[a] = cell_store[fcvu_pkg::SLOT_VEL + a];
            nv[a] = v[a];
            grad[a] = 0;
        end
        if (cfg_mode && rho < cfg_vth)
            r.status = fcvu_pkg::RES_VACUUM;
        else if (rho == 0)
            r.status = fcvu_pkg::RES_ZERO;
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                diff = clamp_word(cell_store[2 * a] - cell_store[2 * a + 1]);
                grad[a] = qmul(diff, cfg_inv[a]);
                q[a] = clamp_word((grad[a] * 65536) / rho);
            end
            if (!cfg_mode)
            begin
                dot = 0;
                for (int a = 0; a < 3; a++)
                    nv[a] = clamp_word(v[a] - qmul(q[a], cfg_dt));
                for (int a = 0; a < 3; a++)
                    dot += qmul(nv[a], grad[a]);
                dot = clamp_word(dot);
                nrho = clamp_word(rho - qmul(dot, cfg_dt));
            end
            else
                for (int a = 0; a < 3; a++)
                begin
                    conn = 0;
                    for (int b = 0; b < 3; b++)
                        for (int c = 0; c < 3; c++)
                            conn += qmul(cell_store[fcvu_pkg::SLOT_COEF + 9 * a + 3 * b + c],
                                         qmul(v[b], v[c]));
                    conn = clamp_word(conn);
                    nv[a] = clamp_word(v[a] - qmul(clamp_word(q[a] + conn), cfg_dt));
                end
            r.status = clamp_seen ? fcvu_pkg::RES_SATURATED : fcvu_pkg::RES_UPDATED;
        end
        r.vx = nv[0][31:0];
        r.vy = nv[1][31:0];
        r.vz = nv[2][31:0];
        r.rho = nrho[31:0];
        return r;
    endfunction

    // handshakes seen at the rising edge
    always @(posedge clk)
    begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        out_taken <= m_axis_tvalid && m_axis_tready;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                void'(pending_loads.pop_front());
                send_wait <= $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
                s_axis_tvalid <= 1'b0;
            end
            else if (send_wait > 0)
                send_wait <= send_wait - 1;
            else if (pending_loads.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {2'b0, pending_loads[0].value, pending_loads[0].slot};
                s_axis_tlast <= pending_loads[0].last;
            end
            if (out_taken)
            begin
                recv_wait <= $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
                m_axis_tready <= 1'b0;
            end
            else if (recv_wait > 0)
                recv_wait <= recv_wait - 1;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cell_result_t got, want;
        load_item_t it;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                it.slot = s_axis_tdata[5:0];
                it.value = s_axis_tdata[37:6];
                it.last = s_axis_tlast;
                if (it.slot < 37)
                    cell_store[it.slot] = longint'($signed(it.value));
                if (it.last)
                    expected_cells.push_back(update_cell());
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                got.vx = m_axis_tdata[31:0];
                got.vy = m_axis_tdata[63:32];
                got.vz = m_axis_tdata[95:64];
                got.rho = m_axis_tdata[127:96];
                got.status = fcvu_pkg::res_status_t'(m_axis_tdata[129:128]);
                if (expected_cells.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    want = expected_cells.pop_front();
                    if (got.vx !== want.vx)
                        report($sformatf("new_vx %h want %h", got.vx, want.vx));
                    if (got.vy !== want.vy)
                        report($sformatf("new_vy %h want %h", got.vy, want.vy));
                    if (got.vz !== want.vz)
                        report($sformatf("new_vz %h want %h", got.vz, want.vz));
                    if (got.rho !== want.rho)
                        report($sformatf("new_density %h want %h", got.rho, want.rho));
                    if (got.status !== want.status)
                        report($sformatf("status %0d want %0d", got.status, want.status));
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fcvu_pkg::REG_MODE: cfg_mode = val[0];
            fcvu_pkg::REG_DT: cfg_dt = val[30:0];
            fcvu_pkg::REG_INV_X: cfg_inv[0] = val[30:0];
            fcvu_pkg::REG_INV_Y: cfg_inv[1] = val[30:0];
            fcvu_pkg::REG_INV_Z: cfg_inv[2] = val[30:0];
            fcvu_pkg::REG_VTH: cfg_vth = val[30:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_word(input int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            2: return $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                           : -$urandom_range(0, 65535);
            default: return $urandom_range(0, 1) ? $urandom_range(0, 8 << 16)
                                                 : -$urandom_range(0, 8 << 16);
        endcase
    endfunction

    task automatic queue_load(input logic [5:0] s, input logic [31:0] v, input logic l);
        load_item_t it;
        it.slot = s;
        it.value = v;
        it.last = l;
        pending_loads.push_back(it);
        if (s < 37)
            written[s] = 1'b1;
    endtask

    // full cell, then random reloads; last always on a loaded cell
    task automatic queue_cell(input int kind, input bit full);
        int n;
        if (full || written != '1)
            for (int s = 0; s < 37; s++)
                queue_load(s, rand_word($urandom_range(0, 9) == 0 ? 1 : kind), 1'b0);
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
            queue_load($urandom_range(0, 63), rand_word(kind), k == n - 1);
    endtask

    task automatic run_phase();
        while (pending_loads.size() > 0 || expected_cells.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        idle_cycles = 0;
        send_wait = 0;
        recv_wait = 0;
        written = '0;
        cfg_mode = 1'b1;
        cfg_dt = 655;
        cfg_inv = '{65536, 65536, 65536};
        cfg_vth = 1;
        for (int s = 0; s < 37; s++)
            cell_store[s] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, then zero, vacuum, extremes, out-of-range slot
        for (int s = 0; s < 37; s++)
            queue_load(s, 32'h0, 1'b0);
        queue_load(fcvu_pkg::SLOT_RHO, 32'h0, 1'b1);
        queue_load(fcvu_pkg::SLOT_RHO, 32'hFFFF0000, 1'b1);
        queue_load(fcvu_pkg::SLOT_VEL, 32'h7FFFFFFF, 1'b0);
        queue_load(fcvu_pkg::SLOT_RHO, 32'h00010000, 1'b0);
        queue_load(6'd0, 32'h7FFFFFFF, 1'b0);
        queue_load(6'd1, 32'h80000000, 1'b0);
        queue_load(6'd63, 32'hFFFFFFFF, 1'b1);
        queue_load(6'd37, 32'h12345678, 1'b1);
        queue_load(fcvu_pkg::SLOT_COEF, 32'h00020000, 1'b0);
        queue_load(6'd36, 32'h80000000, 1'b1);
        run_phase();
        write_reg(fcvu_pkg::REG_MODE, 32'h0);
        write_reg(fcvu_pkg::REG_DT, 32'h7FFFFFFF);
        write_reg(fcvu_pkg::REG_INV_X, 32'h7FFFFFFF);
        write_reg(fcvu_pkg::REG_INV_Y, 32'h0);
        write_reg(fcvu_pkg::REG_INV_Z, 32'h00008000);
        write_reg(fcvu_pkg::REG_VTH, 32'h7FFFFFFF);
        queue_load(6'd2, 32'h00030000, 1'b0);
        queue_load(fcvu_pkg::SLOT_RHO, 32'hFFFE0000, 1'b1);
        queue_load(fcvu_pkg::SLOT_RHO, 32'h0, 1'b1);
        queue_load(fcvu_pkg::SLOT_RHO, 32'h00000001, 1'b1);
        run_phase();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(fcvu_pkg::REG_MODE, ph % 2);
            write_reg(fcvu_pkg::REG_DT, ph == 5 ? 32'h7FFFFFFF
                                                : (ph == 4 ? 32'h0 : $urandom_range(0, 1 << 17)));
            write_reg(fcvu_pkg::REG_INV_X, ph == 3 ? 32'h7FFFFFFF : $urandom_range(0, 1 << 17));
            write_reg(fcvu_pkg::REG_INV_Y, ph == 3 ? 32'h0 : $urandom_range(0, 1 << 17));
            write_reg(fcvu_pkg::REG_INV_Z, $urandom_range(0, 1 << 17));
            write_reg(fcvu_pkg::REG_VTH, ph == 1 ? 32'h0 : $urandom_range(0, 1 << 16));
            for (int c = 0; c < 7; c++)
                queue_cell($urandom_range(0, 3), c == 0);
            for (int k = 0; k < 12; k++)
                queue_load($urandom_range(0, 63), $urandom(), 1'b0);
            queue_load(fcvu_pkg::SLOT_RHO, rand_word(3), 1'b1);
            run_phase();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/fcvu_pkg.sv
rtl/fcvu_div.sv
rtl/fcvu_datapath.sv
rtl/fcvu_ctrl.sv
rtl/fluid_cell_velocity_update_top.sv
tb/fluid_cell_velocity_update_top_test.sv
